/* rtl/mrmc_pkg.sv */
// ----------------------------------------------------------------------------
// mrmc_pkg
// Types and constants shared by the robot mode controller.
// ----------------------------------------------------------------------------
package mrmc_pkg;

  typedef enum logic [2:0] {
    M_STANDBY = 3'd0,
    M_LINE    = 3'd1,
    M_AVOID   = 3'd2,
    M_FOLLOW  = 3'd3,
    M_REMOTE  = 3'd4
  } mode_t;

  localparam logic [2:0] D_STOP  = 3'd0;
  localparam logic [2:0] D_FWD   = 3'd1;
  localparam logic [2:0] D_BACK  = 3'd2;
  localparam logic [2:0] D_RIGHT = 3'd3;
  localparam logic [2:0] D_LEFT  = 3'd4;
  localparam logic [2:0] D_NONE  = 3'd7;

  localparam logic [7:0] IR_OK   = 8'h40;
  localparam logic [7:0] IR_UP   = 8'h46;
  localparam logic [7:0] IR_DN   = 8'h15;
  localparam logic [7:0] IR_LT   = 8'h44;
  localparam logic [7:0] IR_RT   = 8'h43;
  localparam logic [7:0] IR_HASH = 8'h4a;

  localparam logic [2:0] AV_CLEAR  = 3'd0;
  localparam logic [2:0] AV_SCAN_L = 3'd1;
  localparam logic [2:0] AV_SCAN_R = 3'd2;
  localparam logic [2:0] AV_DECIDE = 3'd3;
  localparam logic [2:0] AV_TURN   = 3'd4;
  localparam logic [2:0] AV_BACKUP = 3'd5;

  localparam logic [2:0] FP_FOLLOWING = 3'd5;

  localparam int SCAN_WAIT   = 400;
  localparam int TURN_WAIT   = 300;
  localparam int BACKUP_WAIT = 1000;
  localparam int FOLLOW_SERVO_WAIT = 250;
  localparam int FOLLOW_STEER_WAIT = 200;
  localparam int FOLLOW_MIN = 10;
  localparam int FOLLOW_MAX = 100;

  localparam logic [2:0] LED_LOW_VOLT = 3'd5;
  localparam logic [2:0] LED_LIFTED   = 3'd6;

  localparam logic [2:0] R_SPEED_NORMAL = 3'd0;
  localparam logic [2:0] R_SPEED_LOW    = 3'd1;
  localparam logic [2:0] R_OBSTACLE     = 3'd2;
  localparam logic [2:0] R_COLLISION    = 3'd3;
  localparam logic [2:0] R_MIN_VOLTAGE  = 3'd4;
  localparam logic [2:0] R_GROUND       = 3'd5;
  localparam logic [2:0] R_TRACK_LOW    = 3'd6;
  localparam logic [2:0] R_TRACK_HIGH   = 3'd7;

  typedef struct packed {
    logic [7:0]  speed_normal;
    logic [7:0]  speed_low;
    logic [9:0]  obstacle_threshold_cm;
    logic [9:0]  collision_distance_cm;
    logic [13:0] min_voltage_mv;
    logic [9:0]  ground_level;
    logic [9:0]  track_low;
    logic [9:0]  track_high;
  } cfg_t;

  function automatic logic [7:0] follow_angle(input logic [2:0] p);
    case (p)
      3'd0: follow_angle = 8'd150;
      3'd1: follow_angle = 8'd120;
      3'd2: follow_angle = 8'd90;
      3'd3: follow_angle = 8'd60;
      3'd4: follow_angle = 8'd30;
      default: follow_angle = 8'd90;
    endcase
  endfunction

endpackage

/* rtl/mrmc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mrmc_cfg_regs
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module mrmc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  output mrmc_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_normal          <= 8'd150;
      cfg.speed_low             <= 8'd100;
      cfg.obstacle_threshold_cm <= 10'd30;
      cfg.collision_distance_cm <= 10'd30;
      cfg.min_voltage_mv        <= 14'd6500;
      cfg.ground_level          <= 10'd800;
      cfg.track_low             <= 10'd250;
      cfg.track_high            <= 10'd850;
    end else if (cfg_we) begin
      case (cfg_index)
        mrmc_pkg::R_SPEED_NORMAL: cfg.speed_normal <= cfg_data[7:0];
        mrmc_pkg::R_SPEED_LOW:    cfg.speed_low <= cfg_data[7:0];
        mrmc_pkg::R_OBSTACLE:     cfg.obstacle_threshold_cm <= cfg_data[9:0];
        mrmc_pkg::R_COLLISION:    cfg.collision_distance_cm <= cfg_data[9:0];
        mrmc_pkg::R_MIN_VOLTAGE:  cfg.min_voltage_mv <= cfg_data;
        mrmc_pkg::R_GROUND:       cfg.ground_level <= cfg_data[9:0];
        mrmc_pkg::R_TRACK_LOW:    cfg.track_low <= cfg_data[9:0];
        mrmc_pkg::R_TRACK_HIGH:   cfg.track_high <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/mobile_robot_mode_controller.sv */
// ----------------------------------------------------------------------------
// mobile_robot_mode_controller
// Per-pass mode controller for a two-motor robot with a scanning range sensor.
// ----------------------------------------------------------------------------
// One control pass per transfer. A pass is registered on input, evaluated by
// combinational compare logic against the mode state and registered on output.
// A result moves from the input register to the output register, or to the
// skid entry. A new pass is taken every cycle while the input is not stalled.
// The output register and a one-entry skid buffer keep the input open while a
// result waits. The input stalls while the skid entry is full, or while a pass
// sits in the input register and the output register is full and stalled.
// The feedback loop through the mode, phase and last-sent registers sets this
// one-pass-per-clock limit.
module mobile_robot_mode_controller #(
  parameter int TIME_BITS = 32,
  parameter int ADC_BITS  = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                ir_valid,
  input  logic [7:0]          ir_code,
  input  logic [9:0]          range_cm,
  input  logic [ADC_BITS-1:0] opto_left,
  input  logic [ADC_BITS-1:0] opto_mid,
  input  logic [ADC_BITS-1:0] opto_right,
  input  logic [13:0]         voltage_mv,
  input  logic [31:0]         time_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                motor_update,
  output logic [1:0]          left_drive,
  output logic [1:0]          right_drive,
  output logic [7:0]          drive_speed,
  output logic                servo_update,
  output logic [7:0]          servo_angle,
  output logic [2:0]          mode_now,
  output logic [2:0]          led_pattern,
  output logic                collision_stop
);

  localparam int TB = TIME_BITS;
  localparam int RW = 29;

  mrmc_pkg::cfg_t cfg;

  mrmc_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // input register
  logic                s_valid;
  logic                s_ir_valid;
  logic [7:0]          s_ir_code;
  logic [9:0]          s_range;
  logic [ADC_BITS-1:0] s_ol, s_om, s_or;
  logic [13:0]         s_volt;
  logic [TB-1:0]       s_now;

  // result held in output register and skid entry
  logic [RW-1:0] res, out_r, skid_r;
  logic          skid_valid;
  logic          take_in, fire;

  assign in_stall = skid_valid || (s_valid && out_valid && out_stall);
  assign take_in  = in_valid && !in_stall;
  // stage result always moves on when valid; the input stall keeps room for it
  assign fire     = s_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= take_in;
    end
    if (take_in) begin
      s_ir_valid <= ir_valid;
      s_ir_code  <= ir_code;
      s_range    <= range_cm;
      s_ol       <= opto_left;
      s_om       <= opto_mid;
      s_or       <= opto_right;
      s_volt     <= voltage_mv;
      s_now      <= TB'(time_ms);
    end
  end

  // state
  mrmc_pkg::mode_t op_mode, op_mode_next;
  logic [2:0]    drive_dir, drive_dir_next;
  logic [7:0]    drive_spd, drive_spd_next;
  logic [2:0]    avoid_phase, avoid_phase_next;
  logic [TB-1:0] avoid_servo_time, avoid_servo_time_next;
  logic [TB-1:0] avoid_turn_time, avoid_turn_time_next;
  logic [9:0]    left_distance, left_distance_next;
  logic [9:0]    right_distance, right_distance_next;
  logic [2:0]    follow_phase, follow_phase_next;
  logic [TB-1:0] follow_servo_time, follow_servo_time_next;
  logic [TB-1:0] follow_acquired_time, follow_acquired_time_next;
  logic [2:0]    sent_dir, sent_dir_next;
  logic [8:0]    sent_speed, sent_speed_next;

  logic          r_upd, r_srv, r_coll;
  logic [7:0]    r_deg, r_spd;
  logic [1:0]    r_ld, r_rd;
  logic [2:0]    r_led, dir;
  logic [TB-1:0] d_avs, d_avt, d_fs, d_fa;
  logic          low_volt, lifted;
  logic          drivable;
  logic [2:0]    ir_dir;
  logic          ir_drive;

  function automatic logic in_track(input logic [ADC_BITS-1:0] v,
                                    input logic [9:0] lo, input logic [9:0] hi);
    in_track = (16'(lo) <= 16'(v)) && (16'(v) <= 16'(hi));
  endfunction

  always_comb begin
    op_mode_next = op_mode;
    drive_dir_next = drive_dir;
    drive_spd_next = drive_spd;
    avoid_phase_next = avoid_phase;
    avoid_servo_time_next = avoid_servo_time;
    avoid_turn_time_next = avoid_turn_time;
    left_distance_next = left_distance;
    right_distance_next = right_distance;
    follow_phase_next = follow_phase;
    follow_servo_time_next = follow_servo_time;
    follow_acquired_time_next = follow_acquired_time;
    sent_dir_next = sent_dir;
    sent_speed_next = sent_speed;
    r_srv = 1'b0;
    r_deg = 8'd0;
    r_coll = 1'b0;
    r_led = 3'd0;
    ir_dir = mrmc_pkg::D_STOP;
    ir_drive = 1'b0;
    drivable = 1'b0;

    d_avs = s_now - avoid_servo_time;
    d_avt = s_now - avoid_turn_time;
    d_fs  = s_now - follow_servo_time;
    d_fa  = s_now - follow_acquired_time;

    low_volt = s_volt < cfg.min_voltage_mv;
    lifted = (16'(s_ol) > 16'(cfg.ground_level)) && (16'(s_om) > 16'(cfg.ground_level)) &&
             (16'(s_or) > 16'(cfg.ground_level));

    if (low_volt || lifted) begin
      r_led = low_volt ? mrmc_pkg::LED_LOW_VOLT : mrmc_pkg::LED_LIFTED;
      dir = mrmc_pkg::D_STOP;
      r_spd = 8'd0;
    end else begin
      if (s_ir_valid) begin
        drivable = (op_mode == mrmc_pkg::M_STANDBY) || (op_mode == mrmc_pkg::M_REMOTE);
        case (s_ir_code)
          mrmc_pkg::IR_OK: begin
            drive_dir_next = mrmc_pkg::D_STOP;
            drive_spd_next = 8'd0;
            op_mode_next = mrmc_pkg::M_STANDBY;
          end
          mrmc_pkg::IR_UP: begin ir_dir = mrmc_pkg::D_FWD;   ir_drive = 1'b1; end
          mrmc_pkg::IR_DN: begin ir_dir = mrmc_pkg::D_BACK;  ir_drive = 1'b1; end
          mrmc_pkg::IR_LT: begin ir_dir = mrmc_pkg::D_LEFT;  ir_drive = 1'b1; end
          mrmc_pkg::IR_RT: begin ir_dir = mrmc_pkg::D_RIGHT; ir_drive = 1'b1; end
          mrmc_pkg::IR_HASH: begin
            case (op_mode)
              mrmc_pkg::M_STANDBY: op_mode_next = mrmc_pkg::M_FOLLOW;
              mrmc_pkg::M_FOLLOW:  op_mode_next = mrmc_pkg::M_LINE;
              mrmc_pkg::M_LINE:    op_mode_next = mrmc_pkg::M_AVOID;
              mrmc_pkg::M_AVOID:   op_mode_next = mrmc_pkg::M_REMOTE;
              default:             op_mode_next = mrmc_pkg::M_STANDBY;
            endcase
          end
          default: ;
        endcase
        if (ir_drive && drivable) begin
          drive_dir_next = ir_dir;
          drive_spd_next = cfg.speed_normal;
          op_mode_next = mrmc_pkg::M_REMOTE;
        end
      end
      r_led = op_mode_next;
      case (op_mode_next)
        mrmc_pkg::M_REMOTE: begin
          if (s_range < cfg.collision_distance_cm && drive_dir_next == mrmc_pkg::D_FWD) begin
            op_mode_next = mrmc_pkg::M_STANDBY;
            drive_dir_next = mrmc_pkg::D_STOP;
            drive_spd_next = 8'd0;
            r_coll = 1'b1;
          end
        end
        mrmc_pkg::M_LINE: begin
          drive_spd_next = cfg.speed_normal;
          if (in_track(s_om, cfg.track_low, cfg.track_high))
            drive_dir_next = mrmc_pkg::D_FWD;
          else if (in_track(s_ol, cfg.track_low, cfg.track_high))
            drive_dir_next = mrmc_pkg::D_LEFT;
          else if (in_track(s_or, cfg.track_low, cfg.track_high))
            drive_dir_next = mrmc_pkg::D_RIGHT;
          else begin
            drive_dir_next = mrmc_pkg::D_STOP;
            drive_spd_next = 8'd0;
          end
        end
        mrmc_pkg::M_AVOID: begin
          case (avoid_phase)
            mrmc_pkg::AV_SCAN_L: if (d_avs > TB'(mrmc_pkg::SCAN_WAIT)) begin
              left_distance_next = s_range;
              avoid_phase_next = mrmc_pkg::AV_SCAN_R;
              r_srv = 1'b1; r_deg = 8'd30;
              avoid_servo_time_next = s_now;
            end
            mrmc_pkg::AV_SCAN_R: if (d_avs > TB'(mrmc_pkg::SCAN_WAIT)) begin
              right_distance_next = s_range;
              avoid_phase_next = mrmc_pkg::AV_DECIDE;
              r_srv = 1'b1; r_deg = 8'd90;
              avoid_servo_time_next = s_now;
            end
            mrmc_pkg::AV_DECIDE: if (d_avs > TB'(mrmc_pkg::SCAN_WAIT)) begin
              avoid_turn_time_next = s_now;
              if (left_distance > right_distance &&
                  left_distance > cfg.obstacle_threshold_cm) begin
                drive_dir_next = mrmc_pkg::D_LEFT;
                drive_spd_next = cfg.speed_normal;
                avoid_phase_next = mrmc_pkg::AV_TURN;
              end else if (right_distance > left_distance &&
                           right_distance > cfg.obstacle_threshold_cm) begin
                drive_dir_next = mrmc_pkg::D_RIGHT;
                drive_spd_next = cfg.speed_normal;
                avoid_phase_next = mrmc_pkg::AV_TURN;
              end else begin
                drive_dir_next = mrmc_pkg::D_BACK;
                drive_spd_next = cfg.speed_low;
                avoid_phase_next = mrmc_pkg::AV_BACKUP;
              end
            end
            mrmc_pkg::AV_TURN: if (d_avt > TB'(mrmc_pkg::TURN_WAIT)) begin
              avoid_phase_next = mrmc_pkg::AV_CLEAR;
              drive_dir_next = mrmc_pkg::D_FWD;
              drive_spd_next = cfg.speed_normal;
            end
            mrmc_pkg::AV_BACKUP: if (d_avt > TB'(mrmc_pkg::BACKUP_WAIT)) begin
              drive_dir_next = mrmc_pkg::D_LEFT;
              drive_spd_next = cfg.speed_normal;
              avoid_turn_time_next = s_now;
              avoid_phase_next = mrmc_pkg::AV_TURN;
            end
            default: begin
              avoid_phase_next = mrmc_pkg::AV_CLEAR;
              drive_dir_next = mrmc_pkg::D_FWD;
              drive_spd_next = cfg.speed_normal;
              if (s_range <= cfg.obstacle_threshold_cm) begin
                drive_dir_next = mrmc_pkg::D_STOP;
                drive_spd_next = 8'd0;
                avoid_phase_next = mrmc_pkg::AV_SCAN_L;
                r_srv = 1'b1; r_deg = 8'd150;
                avoid_servo_time_next = s_now;
              end
            end
          endcase
        end
        mrmc_pkg::M_FOLLOW: begin
          if (follow_phase > 3'd4) begin
            follow_phase_next = mrmc_pkg::FP_FOLLOWING;
            if (d_fa >= TB'(mrmc_pkg::FOLLOW_SERVO_WAIT)) begin
              if (s_range < 10'(mrmc_pkg::FOLLOW_MIN)) begin
                drive_dir_next = mrmc_pkg::D_STOP;
                drive_spd_next = 8'd0;
                follow_acquired_time_next = s_now;
              end else if (s_range > 10'(mrmc_pkg::FOLLOW_MAX)) begin
                drive_dir_next = mrmc_pkg::D_STOP;
                drive_spd_next = 8'd0;
                r_srv = 1'b1; r_deg = 8'd150;
                follow_servo_time_next = s_now;
                follow_phase_next = 3'd0;
              end else if (d_fa >= TB'(mrmc_pkg::FOLLOW_SERVO_WAIT +
                                       mrmc_pkg::FOLLOW_STEER_WAIT)) begin
                drive_dir_next = mrmc_pkg::D_FWD;
                drive_spd_next = cfg.speed_normal;
              end
            end
          end else if (d_fs >= TB'(mrmc_pkg::FOLLOW_SERVO_WAIT)) begin
            if (s_range <= 10'(mrmc_pkg::FOLLOW_MAX)) begin
              follow_acquired_time_next = s_now;
              drive_spd_next = cfg.speed_normal;
              if (follow_phase == 3'd0) drive_dir_next = mrmc_pkg::D_LEFT;
              else if (follow_phase == 3'd4) drive_dir_next = mrmc_pkg::D_RIGHT;
              else drive_dir_next = mrmc_pkg::D_FWD;
              r_srv = 1'b1; r_deg = 8'd90;
              follow_phase_next = mrmc_pkg::FP_FOLLOWING;
            end else if (follow_phase < 3'd4) begin
              follow_phase_next = follow_phase + 3'd1;
              r_srv = 1'b1;
              r_deg = mrmc_pkg::follow_angle(follow_phase + 3'd1);
              follow_servo_time_next = s_now;
            end else begin
              // target lost after the last scan position
              r_srv = 1'b1; r_deg = 8'd90;
              op_mode_next = mrmc_pkg::M_STANDBY;
              follow_phase_next = mrmc_pkg::FP_FOLLOWING;
              follow_servo_time_next = '0;
              follow_acquired_time_next = '0;
            end
          end
        end
        default: ;
      endcase
      dir = drive_dir_next;
      r_spd = drive_spd_next;
    end

    r_upd = (dir != sent_dir) || ({1'b0, r_spd} != sent_speed);
    if (r_upd) begin
      sent_dir_next = dir;
      sent_speed_next = {1'b0, r_spd};
    end
    case (dir)
      mrmc_pkg::D_FWD:   begin r_ld = 2'd1; r_rd = 2'd1; end
      mrmc_pkg::D_BACK:  begin r_ld = 2'd2; r_rd = 2'd2; end
      mrmc_pkg::D_RIGHT: begin r_ld = 2'd1; r_rd = 2'd2; end
      mrmc_pkg::D_LEFT:  begin r_ld = 2'd2; r_rd = 2'd1; end
      default: begin r_ld = 2'd0; r_rd = 2'd0; r_spd = 8'd0; end
    endcase
    res = {r_upd, r_ld, r_rd, r_spd, r_srv, r_deg, 3'(op_mode_next), r_led, r_coll};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= mrmc_pkg::M_STANDBY;
      drive_dir <= mrmc_pkg::D_STOP;
      drive_spd <= 8'd0;
      avoid_phase <= mrmc_pkg::AV_CLEAR;
      avoid_servo_time <= '0;
      avoid_turn_time <= '0;
      left_distance <= 10'd0;
      right_distance <= 10'd0;
      follow_phase <= mrmc_pkg::FP_FOLLOWING;
      follow_servo_time <= '0;
      follow_acquired_time <= '0;
      sent_dir <= mrmc_pkg::D_NONE;
      sent_speed <= 9'h1ff;
    end else if (fire) begin
      op_mode <= op_mode_next;
      drive_dir <= drive_dir_next;
      drive_spd <= drive_spd_next;
      avoid_phase <= avoid_phase_next;
      avoid_servo_time <= avoid_servo_time_next;
      avoid_turn_time <= avoid_turn_time_next;
      left_distance <= left_distance_next;
      right_distance <= right_distance_next;
      follow_phase <= follow_phase_next;
      follow_servo_time <= follow_servo_time_next;
      follow_acquired_time <= follow_acquired_time_next;
      sent_dir <= sent_dir_next;
      sent_speed <= sent_speed_next;
    end
  end

  // output register with skid entry; stage 1 always drains because the input
  // stalls whenever the skid entry could be full when the pass reaches it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_r <= skid_r;
          skid_valid <= fire;
          skid_r <= res;
        end else begin
          out_valid <= fire;
          out_r <= res;
        end
      end else if (fire) begin
        skid_valid <= 1'b1;
        skid_r <= res;
      end
    end
  end

  assign {motor_update, left_drive, right_drive, drive_speed, servo_update, servo_angle,
          mode_now, led_pattern, collision_stop} = out_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with empty output");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |-> !fire) else $error("result lost in skid");
  a_speed_zero_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && left_drive == 2'd0) |-> drive_speed == 8'd0)
    else $error("stopped motor with nonzero speed");
  a_servo_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !servo_update) |-> servo_angle == 8'd0)
    else $error("servo angle without update");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the robot mode controller: random control passes
// drive the block under burst/gap and stall patterns, a behavioral model of
// the mode logic predicts every result, and a monitor compares field by field.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic        ir_valid;
    logic [7:0]  ir_code;
    logic [9:0]  range_cm;
    logic [9:0]  ol, om, orr;
    logic [13:0] volt;
    logic [31:0] tms;
  } pass_t;

  typedef struct packed {
    logic       upd;
    logic [1:0] ld, rd;
    logic [7:0] spd;
    logic       supd;
    logic [7:0] sang;
    logic [2:0] mode;
    logic [2:0] led;
    logic       coll;
  } cmd_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic ir_valid = 0;
  logic [7:0] ir_code = '0;
  logic [9:0] range_cm = '0, opto_left = '0, opto_mid = '0, opto_right = '0;
  logic [13:0] voltage_mv = '0;
  logic [31:0] time_ms = '0;
  logic motor_update, servo_update, collision_stop;
  logic [1:0] left_drive, right_drive;
  logic [7:0] drive_speed, servo_angle;
  logic [2:0] mode_now, led_pattern;

  mobile_robot_mode_controller dut (.*);

  initial forever #10 clk = ~clk;

  // model state
  mrmc_pkg::cfg_t cf;
  logic [2:0]  m_mode, m_dir, av_ph, fo_ph, snt_dir;
  logic [7:0]  m_spd;
  logic [8:0]  snt_spd;
  logic [31:0] av_st, av_tt, fo_st, fo_at;
  logic [9:0]  ldist, rdist;
  logic        s_cmd;
  logic [7:0]  s_deg;

  pass_t pending[$];
  cmd_t  expected_cmds[$];
  int    errors = 0, checked = 0, sent = 0;
  logic [31:0] clock_ms = 0;
  logic  in_taken = 0;

  function automatic logic on_line(logic [9:0] v);
    return cf.track_low <= v && v <= cf.track_high;
  endfunction

  function automatic void drive_set(logic [2:0] d, logic [7:0] s);
    m_dir = d; m_spd = s;
  endfunction

  function automatic void aim(logic [7:0] d);
    s_cmd = 1; s_deg = d;
  endfunction

  function automatic void avoid_pass(logic [9:0] r, logic [31:0] now);
    case (av_ph)
      mrmc_pkg::AV_SCAN_L: if (now - av_st > mrmc_pkg::SCAN_WAIT) begin
        ldist = r; av_ph = mrmc_pkg::AV_SCAN_R; aim(30); av_st = now;
      end
      mrmc_pkg::AV_SCAN_R: if (now - av_st > mrmc_pkg::SCAN_WAIT) begin
        rdist = r; av_ph = mrmc_pkg::AV_DECIDE; aim(90); av_st = now;
      end
      mrmc_pkg::AV_DECIDE: if (now - av_st > mrmc_pkg::SCAN_WAIT) begin
        av_tt = now;
        if (ldist > rdist && ldist > cf.obstacle_threshold_cm) begin
          drive_set(mrmc_pkg::D_LEFT, cf.speed_normal); av_ph = mrmc_pkg::AV_TURN;
        end else if (rdist > ldist && rdist > cf.obstacle_threshold_cm) begin
          drive_set(mrmc_pkg::D_RIGHT, cf.speed_normal); av_ph = mrmc_pkg::AV_TURN;
        end else begin
          drive_set(mrmc_pkg::D_BACK, cf.speed_low); av_ph = mrmc_pkg::AV_BACKUP;
        end
      end
      mrmc_pkg::AV_TURN: if (now - av_tt > mrmc_pkg::TURN_WAIT) begin
        av_ph = mrmc_pkg::AV_CLEAR; drive_set(mrmc_pkg::D_FWD, cf.speed_normal);
      end
      mrmc_pkg::AV_BACKUP: if (now - av_tt > mrmc_pkg::BACKUP_WAIT) begin
        drive_set(mrmc_pkg::D_LEFT, cf.speed_normal); av_tt = now;
        av_ph = mrmc_pkg::AV_TURN;
      end
      default: begin
        av_ph = mrmc_pkg::AV_CLEAR; drive_set(mrmc_pkg::D_FWD, cf.speed_normal);
        if (r <= cf.obstacle_threshold_cm) begin
          drive_set(mrmc_pkg::D_STOP, 0); av_ph = mrmc_pkg::AV_SCAN_L; aim(150);
          av_st = now;
        end
      end
    endcase
  endfunction

  function automatic void follow_pass(logic [9:0] r, logic [31:0] now);
    logic [7:0] ang[5];
    ang = '{150, 120, 90, 60, 30};
    if (fo_ph > 4) begin
      fo_ph = mrmc_pkg::FP_FOLLOWING;
      if (now - fo_at >= mrmc_pkg::FOLLOW_SERVO_WAIT) begin
        if (r < mrmc_pkg::FOLLOW_MIN) begin
          drive_set(mrmc_pkg::D_STOP, 0); fo_at = now;
        end else if (r > mrmc_pkg::FOLLOW_MAX) begin
          drive_set(mrmc_pkg::D_STOP, 0); aim(150); fo_st = now; fo_ph = 0;
        end else if (now - fo_at >= mrmc_pkg::FOLLOW_SERVO_WAIT +
                                    mrmc_pkg::FOLLOW_STEER_WAIT) begin
          drive_set(mrmc_pkg::D_FWD, cf.speed_normal);
        end
      end
    end else if (now - fo_st >= mrmc_pkg::FOLLOW_SERVO_WAIT) begin
      if (r <= mrmc_pkg::FOLLOW_MAX) begin
        fo_at = now;
        if (fo_ph == 0) drive_set(mrmc_pkg::D_LEFT, cf.speed_normal);
        else if (fo_ph == 4) drive_set(mrmc_pkg::D_RIGHT, cf.speed_normal);
        else drive_set(mrmc_pkg::D_FWD, cf.speed_normal);
        aim(90); fo_ph = mrmc_pkg::FP_FOLLOWING;
      end else if (fo_ph < 4) begin
        fo_ph++; aim(ang[fo_ph]); fo_st = now;
      end else begin
        aim(90); m_mode = mrmc_pkg::M_STANDBY; fo_ph = mrmc_pkg::FP_FOLLOWING;
        fo_st = 0; fo_at = 0;
      end
    end
  endfunction

  function automatic void remote_key(logic [7:0] code);
    logic ok2drive;
    logic [2:0] d;
    ok2drive = (m_mode == mrmc_pkg::M_STANDBY || m_mode == mrmc_pkg::M_REMOTE);
    d = mrmc_pkg::D_STOP;
    case (code)
      mrmc_pkg::IR_OK: begin
        drive_set(mrmc_pkg::D_STOP, 0); m_mode = mrmc_pkg::M_STANDBY; return;
      end
      mrmc_pkg::IR_UP: d = mrmc_pkg::D_FWD;
      mrmc_pkg::IR_DN: d = mrmc_pkg::D_BACK;
      mrmc_pkg::IR_LT: d = mrmc_pkg::D_LEFT;
      mrmc_pkg::IR_RT: d = mrmc_pkg::D_RIGHT;
      mrmc_pkg::IR_HASH: begin
        case (m_mode)
          mrmc_pkg::M_STANDBY: m_mode = mrmc_pkg::M_FOLLOW;
          mrmc_pkg::M_FOLLOW:  m_mode = mrmc_pkg::M_LINE;
          mrmc_pkg::M_LINE:    m_mode = mrmc_pkg::M_AVOID;
          mrmc_pkg::M_AVOID:   m_mode = mrmc_pkg::M_REMOTE;
          default:             m_mode = mrmc_pkg::M_STANDBY;
        endcase
        return;
      end
      default: return;
    endcase
    if (ok2drive) begin drive_set(d, cf.speed_normal); m_mode = mrmc_pkg::M_REMOTE; end
  endfunction

  function automatic cmd_t control_pass(pass_t p);
    cmd_t c;
    logic [2:0] d;
    logic [7:0] s;
    c = '{default: '0};
    s_cmd = 0; s_deg = 0;
    if (p.volt < cf.min_voltage_mv) begin
      c.led = mrmc_pkg::LED_LOW_VOLT; d = mrmc_pkg::D_STOP; s = 0;
    end else if (p.ol > cf.ground_level && p.om > cf.ground_level &&
                 p.orr > cf.ground_level) begin
      c.led = mrmc_pkg::LED_LIFTED; d = mrmc_pkg::D_STOP; s = 0;
    end else begin
      if (p.ir_valid) remote_key(p.ir_code);
      c.led = m_mode;
      case (m_mode)
        mrmc_pkg::M_REMOTE:
          if (p.range_cm < cf.collision_distance_cm && m_dir == mrmc_pkg::D_FWD) begin
            m_mode = mrmc_pkg::M_STANDBY; drive_set(mrmc_pkg::D_STOP, 0); c.coll = 1;
          end
        mrmc_pkg::M_LINE:
          if (on_line(p.om)) drive_set(mrmc_pkg::D_FWD, cf.speed_normal);
          else if (on_line(p.ol)) drive_set(mrmc_pkg::D_LEFT, cf.speed_normal);
          else if (on_line(p.orr)) drive_set(mrmc_pkg::D_RIGHT, cf.speed_normal);
          else drive_set(mrmc_pkg::D_STOP, 0);
        mrmc_pkg::M_AVOID:  avoid_pass(p.range_cm, p.tms);
        mrmc_pkg::M_FOLLOW: follow_pass(p.range_cm, p.tms);
        default: ;
      endcase
      d = m_dir; s = m_spd;
    end
    if (d != snt_dir || {1'b0, s} != snt_spd) begin
      c.upd = 1; snt_dir = d; snt_spd = {1'b0, s};
    end
    case (d)
      mrmc_pkg::D_FWD:   begin c.ld = 1; c.rd = 1; end
      mrmc_pkg::D_BACK:  begin c.ld = 2; c.rd = 2; end
      mrmc_pkg::D_RIGHT: begin c.ld = 1; c.rd = 2; end
      mrmc_pkg::D_LEFT:  begin c.ld = 2; c.rd = 1; end
      default: s = 0;
    endcase
    c.spd = s; c.supd = s_cmd; c.sang = s_deg; c.mode = m_mode;
    return c;
  endfunction

  // prediction at the input transfer
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) expected_cmds.push_back(control_pass(pending[0]));
  end

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_taken) begin
      // hold payload
    end else begin
      if (in_taken) begin
        pending.pop_front();
        sent++;
      end
      if (gap_left > 0) begin
        gap_left--; in_valid <= 0;
      end else if (pending.size() > 0) begin
        ir_valid <= pending[0].ir_valid; ir_code <= pending[0].ir_code;
        range_cm <= pending[0].range_cm; opto_left <= pending[0].ol;
        opto_mid <= pending[0].om; opto_right <= pending[0].orr;
        voltage_mv <= pending[0].volt; time_ms <= pending[0].tms;
        in_valid <= 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end
      end else in_valid <= 0;
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 97;
    if (stall_phase < 40) out_stall <= 0;
    else if (stall_phase < 60) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // monitor
  always @(posedge clk) begin
    cmd_t e, a;
    if (!rst && out_valid && !out_stall) begin
      a = '{motor_update, left_drive, right_drive, drive_speed, servo_update,
            servo_angle, mode_now, led_pattern, collision_stop};
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = expected_cmds.pop_front();
        checked++;
        if (a !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d exp upd%0d l%0d r%0d s%0d su%0d sa%0d m%0d led%0d c%0d",
                     checked, e.upd, e.ld, e.rd, e.spd, e.supd, e.sang, e.mode, e.led,
                     e.coll, "\n  got upd%0d l%0d r%0d s%0d su%0d sa%0d m%0d led%0d c%0d",
                     a.upd, a.ld, a.rd, a.spd, a.supd, a.sang, a.mode, a.led, a.coll);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [13:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      mrmc_pkg::R_SPEED_NORMAL: cf.speed_normal = v[7:0];
      mrmc_pkg::R_SPEED_LOW:    cf.speed_low = v[7:0];
      mrmc_pkg::R_OBSTACLE:     cf.obstacle_threshold_cm = v[9:0];
      mrmc_pkg::R_COLLISION:    cf.collision_distance_cm = v[9:0];
      mrmc_pkg::R_MIN_VOLTAGE:  cf.min_voltage_mv = v;
      mrmc_pkg::R_GROUND:       cf.ground_level = v[9:0];
      mrmc_pkg::R_TRACK_LOW:    cf.track_low = v[9:0];
      default:                  cf.track_high = v[9:0];
    endcase
  endtask

  task automatic add_pass(logic iv, logic [7:0] code, logic [9:0] r, logic [9:0] ol,
                          logic [9:0] om, logic [9:0] orr, logic [13:0] v);
    pass_t p;
    clock_ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 180);
    p = '{iv, code, r, ol, om, orr, v, clock_ms};
    pending.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || expected_cmds.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // mostly healthy passes with key presses skewed to the known codes
  task automatic random_pass();
    logic [7:0] codes[6];
    logic [7:0] code;
    logic [13:0] v;
    logic [9:0] ol, om, orr;
    codes = '{mrmc_pkg::IR_OK, mrmc_pkg::IR_UP, mrmc_pkg::IR_DN, mrmc_pkg::IR_LT,
              mrmc_pkg::IR_RT, mrmc_pkg::IR_HASH};
    code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : codes[$urandom_range(0, 5)];
    v = ($urandom_range(0, 19) == 0) ? 14'($urandom) : 14'($urandom_range(7000, 16383));
    ol = 10'($urandom); om = 10'($urandom); orr = 10'($urandom);
    if ($urandom_range(0, 4) != 0 && ol > cf.ground_level && om > cf.ground_level)
      orr = 10'($urandom_range(0, 500));
    add_pass($urandom_range(0, 5) == 0, code,
             ($urandom_range(0, 1)) ? 10'($urandom_range(0, 140)) : 10'($urandom),
             ol, om, orr, v);
  endtask

  initial begin
    cf = '{150, 100, 30, 30, 6500, 800, 250, 850};
    m_mode = mrmc_pkg::M_STANDBY; m_dir = mrmc_pkg::D_STOP; m_spd = 0;
    av_ph = mrmc_pkg::AV_CLEAR;
    av_st = 0; av_tt = 0; ldist = 0; rdist = 0; fo_ph = mrmc_pkg::FP_FOLLOWING;
    fo_st = 0; fo_at = 0; snt_dir = mrmc_pkg::D_NONE; snt_spd = 9'h1ff;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: extremes, every key, lift and low-voltage holds
    add_pass(0, 0, 0, 0, 0, 0, 0);
    add_pass(1, mrmc_pkg::IR_UP, 1023, 1023, 1023, 1023, 16383);
    add_pass(1, mrmc_pkg::IR_UP, 1023, 300, 300, 300, 16383);
    add_pass(0, 0, 5, 300, 300, 300, 16383);
    add_pass(1, mrmc_pkg::IR_LT, 200, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_RT, 200, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_DN, 200, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_OK, 200, 0, 0, 0, 9000);
    add_pass(1, 8'hff, 200, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_HASH, 500, 0, 0, 0, 9000);
    for (int i = 0; i < 8; i++) add_pass(0, 0, 500, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_HASH, 0, 900, 300, 0, 9000);
    add_pass(0, 0, 0, 300, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_HASH, 10, 0, 0, 300, 9000);
    for (int i = 0; i < 5; i++) add_pass(0, 0, 10, 0, 0, 0, 9000);
    add_pass(1, mrmc_pkg::IR_HASH, 0, 0, 0, 0, 9000);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: for (int r = 0; r < 8; r++) write_reg(3'(r), 14'h3fff);
        2: for (int r = 0; r < 8; r++) write_reg(3'(r), 0);
        3: begin
          write_reg(mrmc_pkg::R_SPEED_NORMAL, 200); write_reg(mrmc_pkg::R_SPEED_LOW, 60);
          write_reg(mrmc_pkg::R_OBSTACLE, 60); write_reg(mrmc_pkg::R_COLLISION, 45);
          write_reg(mrmc_pkg::R_MIN_VOLTAGE, 7200); write_reg(mrmc_pkg::R_GROUND, 700);
          write_reg(mrmc_pkg::R_TRACK_LOW, 100); write_reg(mrmc_pkg::R_TRACK_HIGH, 600);
        end
        4: begin
          write_reg(mrmc_pkg::R_SPEED_NORMAL, 150); write_reg(mrmc_pkg::R_SPEED_LOW, 100);
          write_reg(mrmc_pkg::R_OBSTACLE, 30); write_reg(mrmc_pkg::R_COLLISION, 30);
          write_reg(mrmc_pkg::R_MIN_VOLTAGE, 6500); write_reg(mrmc_pkg::R_GROUND, 800);
          write_reg(mrmc_pkg::R_TRACK_LOW, 250); write_reg(mrmc_pkg::R_TRACK_HIGH, 850);
        end
        default: ;
      endcase
      for (int i = 0; i < 400; i++) random_pass();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d control passes, %0d results checked, over five register sets",
             sent, checked);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

/* sim.f */
rtl/mrmc_pkg.sv
rtl/mrmc_cfg_regs.sv
rtl/mobile_robot_mode_controller.sv
tb/tb_top.sv
